// ===== rtl/core/aes_pkg.sv =====
// AES-128 package: S-box table, GF(2^8) helpers and round functions.
// Used by all modules under rtl/core; no dependencies.
package aes_pkg;

	localparam int BlkW  = 128;
	localparam int HalfW = 64;
	localparam int NumRounds = 10;

	// APB register indexes
	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW  = 1'b1;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] r;
		case (a)
			8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
			8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
			8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
			8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
			8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
			8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
			8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
			8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
			8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
			8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
			8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
			8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
			8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
			8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
			8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
			8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
			8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
			8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
			8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
			8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
			8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
			8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
			8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
			8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
			8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
			8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
			8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
			8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
			8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
			8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
			8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
			8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
			8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
			8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
			8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
			8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
			8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
			8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
			8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
			8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
			8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
			8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
			8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
			8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
			8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
			8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
			8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
			8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
			8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
			8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
			8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
			8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
			8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; default: r=8'h16;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
	endfunction

	// byte i of a 128-bit block sits at bits 127-8i .. 120-8i
	function automatic logic [7:0] get_byte(input logic [BlkW-1:0] v, input int i);
		return v[BlkW-1-8*i -: 8];
	endfunction

	// next round key from the previous one
	function automatic logic [BlkW-1:0] key_step(input logic [BlkW-1:0] rk,
			input logic [7:0] rcon);
		logic [31:0] t;
		logic [31:0] w0, w1, w2, w3;
		w0 = rk[127:96];
		w1 = rk[95:64];
		w2 = rk[63:32];
		w3 = rk[31:0];
		t = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [BlkW-1:0] sub_shift(input logic [BlkW-1:0] st);
		logic [BlkW-1:0] o;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				o[BlkW-1-8*(4*c+r) -: 8] = sbox(get_byte(st, 4*((c+r)%4)+r));
			end
		end
		return o;
	endfunction

	function automatic logic [BlkW-1:0] mix_cols(input logic [BlkW-1:0] st);
		logic [BlkW-1:0] o;
		logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(st, 4*c);
			a1 = get_byte(st, 4*c+1);
			a2 = get_byte(st, 4*c+2);
			a3 = get_byte(st, 4*c+3);
			b0 = xtime(a0);
			b1 = xtime(a1);
			b2 = xtime(a2);
			b3 = xtime(a3);
			o[BlkW-1-32*c -: 32] = {b0^a1^b1^a2^a3, a0^b1^a2^b2^a3,
				a0^a1^b2^a3^b3, a0^b0^a1^a2^b3};
		end
		return o;
	endfunction

	function automatic logic [7:0] rcon_of(input int round);
		logic [7:0] r;
		r = 8'h01;
		for (int i = 1; i < round; i++) r = xtime(r);
		return r;
	endfunction

endpackage

// ===== rtl/core/aes_round.sv =====
// One registered AES round with its round-key step.
// Depends on aes_pkg.
module aes_round
	import aes_pkg::*;
#(
	parameter int Round = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            valid_in,
	input  logic [BlkW-1:0] state_in,
	input  logic [BlkW-1:0] rkey_in,
	output logic            valid_s1,
	output logic [BlkW-1:0] state_s1,
	output logic [BlkW-1:0] rkey_s1
);
	localparam logic [7:0] Rcon = rcon_of(Round);

	logic [BlkW-1:0] rk_next, sb, mixed;

	assign rk_next = key_step(rkey_in, Rcon);
	assign sb = sub_shift(state_in);
	assign mixed = (Round < NumRounds) ? mix_cols(sb) : sb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_s1 <= mixed ^ rk_next;
			rkey_s1 <= rk_next;
		end
	end
endmodule

// ===== rtl/core/aes_regs.sv =====
// APB key registers for the AES-128 core.
// Depends on aes_pkg.
module aes_regs
	import aes_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	output logic [BlkW-1:0]  key
);
	logic [HalfW-1:0] key_high_q, key_low_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign key = {key_high_q, key_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (wr) begin
			if (paddr == {REG_KEY_HIGH, 3'd0}) begin
				key_high_q <= pwdata;
			end else if (paddr == {REG_KEY_LOW, 3'd0}) begin
				key_low_q <= pwdata;
			end
		end
	end

	always_comb begin
		unique case (paddr)
			{REG_KEY_HIGH, 3'd0}: prdata = key_high_q;
			{REG_KEY_LOW, 3'd0}:  prdata = key_low_q;
			default:              prdata = '0;
		endcase
	end
endmodule

// ===== rtl/core/aes128_block_encrypt.sv =====
// AES-128 encryption core (top level): ten unrolled round stages.
// Depends on aes_pkg, aes_regs, aes_round.
//
// Usage:
//   Input channel in_valid/in_stall carries plain_high/plain_low; output
//   channel out_valid/out_stall carries cipher_high/cipher_low. One
//   ciphertext transaction comes out for every plaintext transaction, in order.
//   The key is written over APB: key_high at 0x0, key_low at 0x8 (64-bit data).
//   Write the key only while the pipe is empty.
// Pipeline:
//   One stage for the initial key addition and one per round. Throughput one
//   block per cycle while no result waits under out_stall; each round stage
//   is S-box, ShiftRows, MixColumns (not in last round) and key-schedule logic.
// Stall:
//   The pipe advances when its last stage is empty or being taken. While a
//   valid result waits under out_stall every stage freezes and in_stall is
//   high, so nothing is lost or repeated; bubbles are not squeezed out.
// Reset:
//   arst_n clears all valid bits and both key registers to zero.
module aes128_block_encrypt
	import aes_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [HalfW-1:0] plain_high,
	input  logic [HalfW-1:0] plain_low,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [HalfW-1:0] cipher_high,
	output logic [HalfW-1:0] cipher_low
);
	logic [BlkW-1:0] key;
	logic advance;
	logic            v   [0:NumRounds];
	logic [BlkW-1:0] st  [0:NumRounds];
	logic [BlkW-1:0] rk  [0:NumRounds];

	aes_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .key
	);

	assign advance = !v[NumRounds] || !out_stall;
	assign in_stall = !advance;

	// stage 0: initial key addition
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (advance) begin
			v[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			st[0] <= {plain_high, plain_low} ^ key;
			rk[0] <= key;
		end
	end

	for (genvar g = 1; g <= NumRounds; g++) begin : g_round
		aes_round #(.Round(g)) u_round (
			.clk, .arst_n, .advance,
			.valid_in(v[g-1]), .state_in(st[g-1]), .rkey_in(rk[g-1]),
			.valid_s1(v[g]), .state_s1(st[g]), .rkey_s1(rk[g])
		);
	end

	assign out_valid = v[NumRounds];
	assign cipher_high = st[NumRounds][BlkW-1:HalfW];
	assign cipher_low = st[NumRounds][HalfW-1:0];

`ifndef NO_ASSERTIONS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
		else $error("result changed under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");
	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");
`endif
endmodule

// ===== tb/sv/aes128_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for aes128_block_encrypt: snoops APB key writes and both channels,
// predicts each ciphertext block and compares it. Depends on aes_pkg.
module aes128_checker
	import aes_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [63:0]      pwdata,
	input  logic             pready,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [HalfW-1:0] plain_high,
	input  logic [HalfW-1:0] plain_low,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [HalfW-1:0] cipher_high,
	input  logic [HalfW-1:0] cipher_low,
	output int               errors,
	output int               pending
);

	logic [7:0]      sub_table [256];
	logic [63:0]     key_hi, key_lo;
	logic [BlkW-1:0] cipher_q [$];

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				r = r ^ a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
		end
		return r;
	endfunction

	function automatic logic [7:0] dbl(input logic [7:0] b);
		return gf_mul(b, 8'h02);
	endfunction

	// S-box from the field inverse (b^254) and the affine map
	initial begin
		logic [7:0] x;
		for (int b = 0; b < 256; b++) begin
			x = 8'h01;
			repeat (254) x = gf_mul(x, 8'(b));
			sub_table[b] = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
				^ {x[3:0], x[7:4]} ^ 8'h63;
		end
	end

	function automatic logic [BlkW-1:0] encrypt_block(input logic [BlkW-1:0] key,
			input logic [BlkW-1:0] plain);
		logic [7:0] s [16];
		logic [7:0] rk [16];
		logic [7:0] tmp [16];
		logic [7:0] t [4];
		logic [7:0] a0, a1, a2, a3, rc;
		logic [BlkW-1:0] res;
		rc = 8'h01;
		for (int i = 0; i < 16; i++) begin
			rk[i] = key[BlkW-1-8*i -: 8];
			s[i]  = plain[BlkW-1-8*i -: 8] ^ rk[i];
		end
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					tmp[4*c+r] = sub_table[s[4*((c+r)%4)+r]];
			s = tmp;
			if (rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
					s[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
					s[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
					s[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
					s[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
				end
			end
			t[0] = sub_table[rk[13]] ^ rc;
			t[1] = sub_table[rk[14]];
			t[2] = sub_table[rk[15]];
			t[3] = sub_table[rk[12]];
			for (int w = 0; w < 4; w++)
				for (int j = 0; j < 4; j++) begin
					rk[4*w+j] = rk[4*w+j] ^ t[j];
					t[j] = rk[4*w+j];
				end
			rc = dbl(rc);
			for (int i = 0; i < 16; i++)
				s[i] = s[i] ^ rk[i];
		end
		for (int i = 0; i < 16; i++)
			res[BlkW-1-8*i -: 8] = s[i];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [BlkW-1:0] exp_blk;
		if (!arst_n) begin
			key_hi  = '0;
			key_lo  = '0;
			errors  = 0;
			cipher_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_KEY_HIGH, 3'b000})
					key_hi = pwdata;
				else if (paddr == {REG_KEY_LOW, 3'b000})
					key_lo = pwdata;
			end
			if (in_valid && !in_stall)
				cipher_q.push_back(encrypt_block({key_hi, key_lo}, {plain_high, plain_low}));
			if (out_valid && !out_stall) begin
				if (cipher_q.size() == 0) begin
					errors++;
					$error("unexpected ciphertext transaction %h %h", cipher_high, cipher_low);
				end else begin
					exp_blk = cipher_q.pop_front();
					if (cipher_high !== exp_blk[127:64]) begin
						errors++;
						$error("cipher_high: expected %h, got %h", exp_blk[127:64], cipher_high);
					end
					if (cipher_low !== exp_blk[63:0]) begin
						errors++;
						$error("cipher_low: expected %h, got %h", exp_blk[63:0], cipher_low);
					end
				end
			end
			pending = cipher_q.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Top of the aes128_block_encrypt testbench: clock, reset, APB key writes,
// plaintext stimulus and output stalls. Depends on aes_pkg and aes128_checker.
module tb;
	import aes_pkg::*;

	logic             clk, arst_n;
	logic             psel, penable, pwrite, pready;
	logic [3:0]       paddr;
	logic [63:0]      pwdata, prdata;
	logic             in_valid, in_stall, out_valid, out_stall;
	logic [HalfW-1:0] plain_high, plain_low, cipher_high, cipher_low;
	int               errors, pending;
	int               send_pct, stall_pct;
	bit               hold_out;
	int unsigned      cycles;

	aes128_block_encrypt dut (.*);
	aes128_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// receiver: random stalls, or a long hold-off while hold_out is set
	always @(posedge clk)
		out_stall <= hold_out || ($urandom_range(99) < stall_pct);

	task automatic apb_write(input logic [0:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 3'b000}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic load_key(input logic [127:0] key);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (16) @(posedge clk);
		apb_write(REG_KEY_HIGH, key[127:64]);
		apb_write(REG_KEY_LOW, key[63:0]);
	endtask

	task automatic send_block(input logic [127:0] blk);
		if ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		{plain_high, plain_low} <= blk;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [127:0] rand_block();
		logic [127:0] b;
		b = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(7))
			0: b = '0;
			1: b = '1;
			2: b = 128'b1 << $urandom_range(127);
			3: b = ~(128'b1 << $urandom_range(127));
			default: ;
		endcase
		return b;
	endfunction

	task automatic random_phase(input int n, input int sp, input int op);
		send_pct = sp;
		stall_pct = op;
		repeat (n) send_block(rand_block());
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; plain_high = '0; plain_low = '0; out_stall = 1'b0;
		send_pct = 0; stall_pct = 0; hold_out = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// never-written key is all zero
		send_block('0);
		send_block('1);
		load_key(128'h000102030405060708090a0b0c0d0e0f);
		send_block(128'h00112233445566778899aabbccddeeff);
		send_block('0);
		send_block('1);
		send_block({64{2'b10}});
		send_block({64{2'b01}});
		for (int i = 0; i < 8; i++)
			send_block(128'h80 << (16 * i + i));
		in_valid <= 1'b0;
		load_key('1);
		send_block('0);
		send_block('1);
		send_block(128'h1);
		in_valid <= 1'b0;
		load_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
		send_block(128'h6bc1bee22e409f96e93d7e117393172a);
		send_block(128'h80000000000000000000000000000001);
		in_valid <= 1'b0;

		load_key({$urandom, $urandom, $urandom, $urandom});
		random_phase(300, 0, 0);
		load_key({$urandom, $urandom, $urandom, $urandom});
		random_phase(250, 75, 0);
		load_key('0);
		random_phase(250, 0, 75);
		load_key({$urandom, $urandom, $urandom, $urandom});
		random_phase(300, 9, 9);

		// long output hold-off so the pipe fills and pushes back
		load_key('1);
		fork
			begin
				hold_out = 1'b1;
				repeat (300) @(posedge clk);
				hold_out = 1'b0;
			end
			random_phase(200, 0, 0);
		join
		load_key({$urandom, $urandom, $urandom, $urandom});
		random_phase(200, 30, 30);

		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== aes128_block_encrypt.f =====
rtl/core/aes_pkg.sv
rtl/core/aes_round.sv
rtl/core/aes_regs.sv
rtl/core/aes128_block_encrypt.sv
tb/sv/aes128_checker.sv
tb/sv/tb.sv
